[hw/rtl/distance_change_detector_core_defines.svh]
// assertion macros shared by the distance change detector rtl
`ifndef DISTANCE_CHANGE_DETECTOR_CORE_DEFINES_SVH
`define DISTANCE_CHANGE_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define DCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define DCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dcd_pkg.sv]
// shared types and constants of the distance change detector
`default_nettype none

package dcd_pkg;

	// operation codes of an input beat
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELAY      = 2'd2;

	// register and counter widths
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned THR_W   = 23;
	localparam logic [6:0]  CM_SCALE = 7'd100;

	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_STABLE = 2'd1,
		MODE_CHANGE = 2'd2,
		MODE_PULSE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_STABLE  = 2'd1,
		EV_CHANGE  = 2'd2,
		EV_IGNORED = 2'd3
	} event_t;

	// control state of the detector, distances travel separately
	typedef struct packed {
		mode_t            mode;
		logic             primed;
		logic [CFG_W-1:0] run;
		logic [CFG_W-1:0] timer;
		logic             led;
	} dcd_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/dcd_if.sv]
// sample and result channel interfaces of the distance change detector
`default_nettype none

interface dcd_in_if #(
	parameter int unsigned DW = 20
);
	logic          valid;
	logic          ready;
	logic          operation;
	logic [DW-1:0] distance;
	logic          measurement_ok;

	modport source (output valid, output operation, output distance,
		output measurement_ok, input ready);
	modport sink (input valid, input operation, input distance,
		input measurement_ok, output ready);
endinterface

interface dcd_out_if #(
	parameter int unsigned DW = 20
);
	logic                valid;
	logic                ready;
	dcd_pkg::mode_t      mode;
	dcd_pkg::event_t     event_res;
	logic [DW-1:0]       stable_distance;
	logic [15:0]         run_count;
	logic                red_led;
	logic                relay_on;

	modport source (output valid, output mode, output event_res,
		output stable_distance, output run_count, output red_led,
		output relay_on, input ready);
	modport sink (input valid, input mode, input event_res,
		input stable_distance, input run_count, input red_led,
		input relay_on, output ready);
endinterface

`default_nettype wire

[hw/rtl/distance_change_detector_core.sv]
// Distance change detector, top level.
//
// Usage: beats on the item channel carry either a distance sample
// (operation 0) or a one-second tick (operation 1). Every accepted beat
// yields exactly one beat on the result channel with the mode, the event,
// the latched stable distance, the run count and the lamp outputs as they
// stand after that beat. The three registers are to be written through
// cfg_we, cfg_index and cfg_data only while no beat is in flight; the
// block itself does not enforce it. An accepted beat waits in the input
// register, is applied to the state and captured in the result register
// once the result slot is free, and then shows as a valid result.
// Throughput: one beat per cycle; the state update is one pass of compare
// and count logic between the input register and the result register.
// Stall: while a result waits, the input register still takes one beat;
// further beats wait until the result is taken. Nothing is dropped.
// Reset: arst_n clears the state to searching, unprimed, all counts zero,
// and clears the registers to zero.
`default_nettype none

module distance_change_detector_core #(
	parameter int unsigned DISTANCE_WIDTH = 20
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	dcd_in_if.sink                          item,
	dcd_out_if.source                       result,
	input  wire logic                       cfg_we,
	input  wire logic [dcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dcd_pkg::CFG_W-1:0]  cfg_data
);
	import dcd_pkg::*;

	`include "distance_change_detector_core_defines.svh"

	logic [CFG_W-1:0]          hysteresis_q;
	logic [CFG_W-1:0]          required_q;
	logic [CFG_W-1:0]          relay_q;

	logic                      valid_s1;
	logic                      operation_s1;
	logic [DISTANCE_WIDTH-1:0] distance_s1;

	dcd_ctl_t                  ctl_q;
	dcd_ctl_t                  ctl_d;
	logic [DISTANCE_WIDTH-1:0] prev_q;
	logic [DISTANCE_WIDTH-1:0] prev_d;
	logic [DISTANCE_WIDTH-1:0] latched_q;
	logic [DISTANCE_WIDTH-1:0] latched_d;
	event_t                    ev;

	logic                      res_valid_q;
	mode_t                     res_mode_q;
	event_t                    res_event_q;
	logic [DISTANCE_WIDTH-1:0] res_stable_q;
	logic [CFG_W-1:0]          res_run_q;
	logic                      res_led_q;
	logic                      res_relay_q;

	logic                      advance;
	logic                      load_s1;
	logic                      fire;

	// handshake: result slot frees on take, input stage refills on advance
	assign advance    = !res_valid_q || result.ready;
	assign load_s1    = advance || !valid_s1;
	assign fire       = valid_s1 && advance;
	assign item.ready = load_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hysteresis_q <= '0;
			required_q   <= '0;
			relay_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HYSTERESIS: hysteresis_q <= cfg_data;
				CFG_REQUIRED:   required_q   <= cfg_data;
				CFG_RELAY:      relay_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	dcd_in_stage #(
		.DISTANCE_WIDTH(DISTANCE_WIDTH)
	) u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load_s1),
		.beat_valid    (item.valid),
		.operation     (item.operation),
		.distance      (item.distance),
		.measurement_ok(item.measurement_ok),
		.valid_s1      (valid_s1),
		.operation_s1  (operation_s1),
		.distance_s1   (distance_s1)
	);

	dcd_step #(
		.DISTANCE_WIDTH(DISTANCE_WIDTH)
	) u_step (
		.ctl_q           (ctl_q),
		.prev_q          (prev_q),
		.latched_q       (latched_q),
		.operation       (operation_s1),
		.distance        (distance_s1),
		.hysteresis_cm   (hysteresis_q),
		.required_samples(required_q),
		.relay_seconds   (relay_q),
		.ctl_d           (ctl_d),
		.prev_d          (prev_d),
		.latched_d       (latched_d),
		.ev              (ev)
	);

	// detector state, updated once per applied beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q     <= '{mode: MODE_SEARCH, primed: 1'b0, run: '0, timer: '0, led: 1'b0};
			prev_q    <= '0;
			latched_q <= '0;
		end else if (fire) begin
			ctl_q     <= ctl_d;
			prev_q    <= prev_d;
			latched_q <= latched_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_mode_q   <= ctl_d.mode;
			res_event_q  <= ev;
			res_stable_q <= latched_d;
			res_run_q    <= ctl_d.run;
			res_led_q    <= ctl_d.led;
			res_relay_q  <= (ctl_d.mode == MODE_PULSE);
		end
	end

	assign result.valid           = res_valid_q;
	assign result.mode            = res_mode_q;
	assign result.event_res       = res_event_q;
	assign result.stable_distance = res_stable_q;
	assign result.run_count       = res_run_q;
	assign result.red_led         = res_led_q;
	assign result.relay_on        = res_relay_q;

	// checks on the detector state and the result beat
	`DCD_ASSERT_NOW(a_led_only_stable, clk, arst_n, ctl_q.led, ctl_q.mode == MODE_STABLE, "red led lit outside stable mode")
	`DCD_ASSERT_NOW(a_pulse_timer_live, clk, arst_n, ctl_q.mode == MODE_PULSE, ctl_q.timer != '0, "relay pulse with expired timer")
	`DCD_ASSERT_NOW(a_relay_matches_mode, clk, arst_n, result.valid, result.relay_on == (result.mode == MODE_PULSE), "relay output disagrees with mode")
	`DCD_ASSERT_NEXT(a_run_needs_prime, clk, arst_n, fire && (ctl_d.run != '0), ctl_q.primed, "run counted before first sample")

endmodule

`default_nettype wire

[hw/rtl/dcd_in_stage.sv]
// input register: captures one beat, failed samples folded to distance zero
`default_nettype none

module dcd_in_stage #(
	parameter int unsigned DISTANCE_WIDTH = 20
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic                      beat_valid,
	input  wire logic                      operation,
	input  wire logic [DISTANCE_WIDTH-1:0] distance,
	input  wire logic                      measurement_ok,
	output      logic                      valid_s1,
	output      logic                      operation_s1,
	output      logic [DISTANCE_WIDTH-1:0] distance_s1
);
	import dcd_pkg::*;

	// stage valid follows the input whenever the stage may be refilled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= beat_valid;
		end
	end

	// payload capture, a failed measurement counts as distance zero
	always_ff @(posedge clk) begin
		if (load && beat_valid) begin
			operation_s1 <= operation;
			distance_s1  <= measurement_ok ? distance : '0;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dcd_step.sv]
// next-state logic: one sample or tick applied to the detector state
`default_nettype none

module dcd_step #(
	parameter int unsigned DISTANCE_WIDTH = 20
) (
	input  wire dcd_pkg::dcd_ctl_t         ctl_q,
	input  wire logic [DISTANCE_WIDTH-1:0] prev_q,
	input  wire logic [DISTANCE_WIDTH-1:0] latched_q,
	input  wire logic                      operation,
	input  wire logic [DISTANCE_WIDTH-1:0] distance,
	input  wire logic [15:0]               hysteresis_cm,
	input  wire logic [15:0]               required_samples,
	input  wire logic [15:0]               relay_seconds,
	output      dcd_pkg::dcd_ctl_t         ctl_d,
	output      logic [DISTANCE_WIDTH-1:0] prev_d,
	output      logic [DISTANCE_WIDTH-1:0] latched_d,
	output      dcd_pkg::event_t           ev
);
	import dcd_pkg::*;

	localparam int unsigned CW = (DISTANCE_WIDTH > THR_W) ? DISTANCE_WIDTH : THR_W;

	logic [THR_W-1:0]          thr;
	logic [DISTANCE_WIDTH-1:0] dev_prev;
	logic [DISTANCE_WIDTH-1:0] dev_latched;
	logic [CW-1:0]             thr_x;
	logic [CW-1:0]             dev_prev_x;
	logic [CW-1:0]             dev_latched_x;
	logic [CFG_W:0]            run_next;
	logic                      run_done;
	logic [CFG_W-1:0]          timer_next;

	// threshold in hundredths and the two absolute deviations
	assign thr           = THR_W'(hysteresis_cm) * THR_W'(CM_SCALE);
	assign dev_prev      = (distance >= prev_q) ? (distance - prev_q)
		: (prev_q - distance);
	assign dev_latched   = (distance >= latched_q) ? (distance - latched_q)
		: (latched_q - distance);
	assign thr_x         = CW'(thr);
	assign dev_prev_x    = CW'(dev_prev);
	assign dev_latched_x = CW'(dev_latched);

	// run counter step, the run qualifies once it exceeds the required count
	assign run_next   = {1'b0, ctl_q.run} + {{CFG_W{1'b0}}, 1'b1};
	assign run_done   = run_next > {1'b0, required_samples};
	assign timer_next = (ctl_q.timer != '0) ? (ctl_q.timer - 1'b1) : ctl_q.timer;

	// mode update
	always_comb begin
		ctl_d     = ctl_q;
		prev_d    = prev_q;
		latched_d = latched_q;
		ev        = EV_NONE;
		if (operation == OP_TICK) begin
			if (ctl_q.mode == MODE_PULSE) begin
				ctl_d.timer = timer_next;
				if (timer_next == '0) begin
					ctl_d.mode = MODE_SEARCH;
				end
			end
		end else if (ctl_q.mode == MODE_PULSE) begin
			ev = EV_IGNORED;
		end else if (!ctl_q.primed) begin
			prev_d       = distance;
			ctl_d.primed = 1'b1;
		end else begin
			unique case (ctl_q.mode)
				MODE_SEARCH: begin
					if (dev_prev_x < thr_x) begin
						if (run_done) begin
							ctl_d.run  = '0;
							ctl_d.mode = MODE_STABLE;
							latched_d  = distance;
							ev         = EV_STABLE;
						end else begin
							ctl_d.run = run_next[CFG_W-1:0];
						end
					end else begin
						ctl_d.run = '0;
					end
				end
				MODE_STABLE: begin
					if (dev_latched_x > thr_x) begin
						if (run_done) begin
							ctl_d.run  = '0;
							ctl_d.led  = 1'b0;
							ctl_d.mode = MODE_CHANGE;
							ev         = EV_CHANGE;
						end else begin
							ctl_d.run = run_next[CFG_W-1:0];
							ctl_d.led = 1'b1;
						end
					end else begin
						ctl_d.run = '0;
						ctl_d.led = 1'b0;
					end
				end
				default: begin
					// change confirmed: this sample starts the relay pulse, or returns to search if relay_seconds is zero
					ctl_d.timer = relay_seconds;
					ctl_d.mode  = (relay_seconds == '0) ? MODE_SEARCH : MODE_PULSE;
				end
			endcase
			prev_d = distance;
		end
	end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for the distance change detector: directed beats, run-count sweep, random scenes
`timescale 1ns / 1ps

module tb_top;
	import dcd_pkg::*;

	localparam logic [19:0] DIST_MAX   = 20'hFFFFF;
	localparam int          HOLD_LEN   = 150;
	localparam int          STALL_LIMIT = 1000;
	localparam int          PHASES     = 8;
	localparam int          PHASE_BEATS = 115;
	localparam int          LONG_RUN   = 40;
	localparam int          LONG_PULSE = 6;

	typedef struct {
		logic        op;
		logic [19:0] dist_val;
		logic        ok;
	} item_t;

	typedef struct {
		mode_t       mode;
		event_t      ev;
		logic [19:0] stable;
		logic [15:0] run;
		logic        led;
		logic        relay;
	} outcome_t;

	// tracks detector state and holds the outcomes still owed by the block
	class change_scoreboard;
		logic [15:0] hyst_cm;
		logic [15:0] need_runs;
		logic [15:0] relay_len;
		mode_t       mode_now;
		bit          primed;
		logic [19:0] last_dist;
		logic [19:0] held_dist;
		logic [15:0] run_len;
		logic [15:0] pulse_left;
		bit          lamp;
		outcome_t    due[$];
		int          errors;
		int          beats;
		int          ignored;
		int          stables;
		int          changes;

		function new();
			hyst_cm = '0;
			need_runs = '0;
			relay_len = '0;
			mode_now = MODE_SEARCH;
			primed = 1'b0;
			last_dist = '0;
			held_dist = '0;
			run_len = '0;
			pulse_left = '0;
			lamp = 1'b0;
			errors = 0;
			beats = 0;
			ignored = 0;
			stables = 0;
			changes = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_HYSTERESIS: hyst_cm = v;
				CFG_REQUIRED:   need_runs = v;
				CFG_RELAY:      relay_len = v;
				default: ;
			endcase
		endfunction

		function int unsigned span(logic [19:0] a, logic [19:0] b);
			return (a >= b) ? 32'(a) - 32'(b) : 32'(b) - 32'(a);
		endfunction

		// count one qualifying sample, true once the run exceeds the required count
		function bit run_done();
			logic [16:0] nxt;
			nxt = {1'b0, run_len} + 17'd1;
			if (nxt > {1'b0, need_runs}) begin
				run_len = '0;
				return 1'b1;
			end
			run_len = nxt[15:0];
			return 1'b0;
		endfunction

		function outcome_t predict(item_t it);
			logic [19:0]  d;
			int unsigned  thr;
			event_t       ev;
			outcome_t     o;
			ev = EV_NONE;
			thr = 32'(hyst_cm) * 100;
			if (it.op == OP_SAMPLE) begin
				d = it.ok ? it.dist_val : '0;
				if (mode_now == MODE_PULSE) begin
					ev = EV_IGNORED;
				end else if (!primed) begin
					last_dist = d;
					primed = 1'b1;
				end else begin
					case (mode_now)
						MODE_SEARCH: begin
							if (span(d, last_dist) < thr) begin
								if (run_done()) begin
									held_dist = d;
									mode_now = MODE_STABLE;
									ev = EV_STABLE;
								end
							end else begin
								run_len = '0;
							end
						end
						MODE_STABLE: begin
							if (span(d, held_dist) > thr) begin
								lamp = 1'b1;
								if (run_done()) begin
									lamp = 1'b0;
									mode_now = MODE_CHANGE;
									ev = EV_CHANGE;
								end
							end else begin
								lamp = 1'b0;
								run_len = '0;
							end
						end
						default: begin
							// change confirmed, this sample starts the relay pulse, or returns to search if relay_len is zero
							pulse_left = relay_len;
							mode_now = (relay_len == 0) ? MODE_SEARCH : MODE_PULSE;
						end
					endcase
					last_dist = d;
				end
			end else if (mode_now == MODE_PULSE) begin
				if (pulse_left != 0)
					pulse_left = pulse_left - 16'd1;
				if (pulse_left == 0)
					mode_now = MODE_SEARCH;
			end
			o.mode = mode_now;
			o.ev = ev;
			o.stable = held_dist;
			o.run = run_len;
			o.led = lamp;
			o.relay = (mode_now == MODE_PULSE);
			return o;
		endfunction

		function void accept_item(item_t it);
			outcome_t o;
			o = predict(it);
			due.push_back(o);
			beats++;
			if (o.ev == EV_IGNORED)
				ignored++;
			if (o.ev == EV_STABLE)
				stables++;
			if (o.ev == EV_CHANGE)
				changes++;
		endfunction

		function void differ(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (due.size() == 0) begin
				$display("%0t: result beat with nothing expected, mode %0d event %0d",
					$time, got.mode, got.ev);
				errors++;
				return;
			end
			want = due.pop_front();
			differ("mode", want.mode, got.mode);
			differ("event_res", want.ev, got.ev);
			differ("stable_distance", want.stable, got.stable);
			differ("run_count", want.run, got.run);
			differ("red_led", want.led, got.led);
			differ("relay_on", want.relay, got.relay);
		endfunction

		function int waiting();
			return due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	dcd_in_if  #(.DW(20)) item_if ();
	dcd_out_if #(.DW(20)) res_if ();

	distance_change_detector_core #(.DISTANCE_WIDTH(20)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	change_scoreboard sb = new();

	bit          idle_en;
	int          hold_requests;
	int          holds_served;
	int          hold_left;
	int          idle_cycles;
	int unsigned scene_base;
	int unsigned scene_jitter;

	logic [15:0] hyst_tab[PHASES]  = '{16'd5, 16'd0, 16'd65535, 16'd1, 16'd20, 16'd3, 16'd10, 16'd2};
	logic [15:0] runs_tab[PHASES]  = '{16'd2, 16'd0, 16'd0, 16'd4, 16'd1, 16'd6, 16'd0, 16'd3};
	logic [15:0] relay_tab[PHASES] = '{16'd3, 16'd0, 16'd1, 16'd5, 16'd2, 16'd8, 16'd0, 16'd4};

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// result side: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_left == 0 && holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_LEN;
		end
		if (hold_left != 0) begin
			res_if.ready <= 1'b0;
			hold_left--;
		end else begin
			res_if.ready <= !(idle_en && $urandom_range(99) < 6);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result('{mode: res_if.mode, ev: res_if.event_res,
				stable: res_if.stable_distance, run: res_if.run_count,
				led: res_if.red_led, relay: res_if.relay_on});
	end

	// watchdog on cycles without any accepted beat
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout after %0d cycles without a beat", STALL_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic item_t beat_of(logic op, logic [19:0] d, logic ok);
		item_t it;
		it.op = op;
		it.dist_val = d;
		it.ok = ok;
		return it;
	endfunction

	// random beat around the current scene distance
	function automatic item_t roam_item();
		item_t       it;
		int unsigned pick;
		int          d;
		pick = $urandom_range(99);
		it.op = OP_SAMPLE;
		it.ok = 1'b1;
		it.dist_val = 20'($urandom());
		if (pick < 15) begin
			it.op = OP_TICK;
		end else if (pick < 18) begin
			it.ok = 1'b0;
		end else if (pick >= 21) begin
			// occasionally move the scene, now and then to a range end
			if (pick < 25)
				scene_base = (pick < 22) ? ($urandom_range(1) ? DIST_MAX : 0)
					: $urandom_range(DIST_MAX);
			d = int'(scene_base) + int'($urandom_range(2 * scene_jitter)) - int'(scene_jitter);
			if (d < 0)
				d = 0;
			if (d > int'(DIST_MAX))
				d = int'(DIST_MAX);
			it.dist_val = d[19:0];
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		@(negedge clk);
		while (idle_en && $urandom_range(99) < 6) begin
			item_if.valid <= 1'b0;
			@(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.operation <= it.op;
		item_if.distance <= it.dist_val;
		item_if.measurement_ok <= it.ok;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		sb.accept_item(it);
	endtask

	// stop offering and let every owed result come back
	task automatic settle();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_register(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(input logic [15:0] hyst, input logic [15:0] runs,
		input logic [15:0] relay);
		write_reg(CFG_HYSTERESIS, hyst);
		write_reg(CFG_REQUIRED, runs);
		write_reg(CFG_RELAY, relay);
	endtask

	initial begin
		int unsigned mark;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_if.valid = 1'b0;
		item_if.operation = OP_SAMPLE;
		item_if.distance = '0;
		item_if.measurement_ok = 1'b0;
		res_if.ready = 1'b0;
		idle_en = 1'b1;
		hold_requests = 0;
		holds_served = 0;
		hold_left = 0;
		scene_base = 50000;
		scene_jitter = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: settle, deviate, confirm, pulse and return
		set_all(16'd1, 16'd2, 16'd2);
		send_item(beat_of(OP_SAMPLE, 20'd5000, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd5050, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd5000, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd5020, 1'b1));
		send_item(beat_of(OP_TICK, 20'd0, 1'b0));
		send_item(beat_of(OP_SAMPLE, 20'd5020, 1'b0));
		send_item(beat_of(OP_SAMPLE, 20'd5020, 1'b1));
		send_item(beat_of(OP_SAMPLE, DIST_MAX, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd0, 1'b1));
		send_item(beat_of(OP_SAMPLE, DIST_MAX, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd777, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd4444, 1'b1));
		send_item(beat_of(OP_TICK, DIST_MAX, 1'b1));
		send_item(beat_of(OP_TICK, 20'd0, 1'b0));
		settle();

		// full-scale hysteresis with no run needed, then zero hysteresis and empty pulse
		set_all(16'd65535, 16'd0, 16'd0);
		send_item(beat_of(OP_SAMPLE, 20'd100, 1'b1));
		settle();
		write_reg(CFG_HYSTERESIS, 16'd0);
		send_item(beat_of(OP_SAMPLE, 20'd101, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd200, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd200, 1'b1));
		send_item(beat_of(OP_TICK, 20'd0, 1'b0));
		settle();

		// long required run: the count climbs through every value before latching
		set_all(16'd10, 16'(LONG_RUN), 16'(LONG_PULSE));
		for (int i = 0; i < LONG_RUN + 2; i++)
			send_item(beat_of(OP_SAMPLE, 20'd3000, 1'b1));
		settle();
		write_reg(CFG_REQUIRED, 16'd1);
		send_item(beat_of(OP_SAMPLE, 20'd900000, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd900000, 1'b1));
		send_item(beat_of(OP_SAMPLE, 20'd5, 1'b1));
		for (int i = 0; i < LONG_PULSE; i++)
			send_item(beat_of(OP_TICK, 20'd0, 1'b0));
		settle();

		// random scenes under several register settings
		for (int p = 0; p < PHASES; p++) begin
			settle();
			set_all(hyst_tab[p], runs_tab[p], relay_tab[p]);
			scene_jitter = 32'(hyst_tab[p]) * 100;
			if (p % 2 == 0)
				scene_jitter = scene_jitter / 2;
			idle_en = (p != 3);
			if (p == 4)
				hold_requests++;
			mark = sb.beats - sb.ignored;
			while (sb.beats - sb.ignored - mark < PHASE_BEATS)
				send_item(roam_item());
		end
		settle();

		$display("covered %0d beats (%0d ignored in relay pulses), %0d stable latches, %0d changes",
			sb.beats, sb.ignored, sb.stables, sb.changes);
		$display("register settings swept %0d random phases plus zero and full-scale cases",
			PHASES);
		if (sb.errors == 0 && sb.waiting() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
